/* rtl/core/ps2mpt_pkg.sv */
package ps2mpt_pkg;

    // Screen size registers as written through the config port
    localparam int SCR_BITS = 13;
    typedef logic [SCR_BITS-1:0] scr_size_t;

    // 9-bit two's complement movement of one packet
    typedef logic signed [8:0] delta_t;

    typedef logic [1:0] byte_idx_t;

    // Config bus
    localparam int PDATA_BITS = 32;
    localparam int PADDR_BITS = 3;
    localparam logic [PADDR_BITS-1:0] ADDR_SCREEN_W = 3'd0;
    localparam logic [PADDR_BITS-1:0] ADDR_SCREEN_H = 3'd4;

    localparam scr_size_t SCREEN_W_RESET = 13'd640;
    localparam scr_size_t SCREEN_H_RESET = 13'd480;

    // Packet layout: byte 0 carries buttons and the sign bits
    localparam byte_idx_t BYTE_IDX_LAST = 2'd2;
    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

endpackage

/* rtl/core/ps2mpt_in_if.sv */
interface ps2mpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

/* rtl/core/ps2mpt_out_if.sv */
interface ps2mpt_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [2:0]            buttons;
    logic signed [8:0]     delta_x;
    logic signed [8:0]     delta_y;

    modport source (
        output valid, output pos_x, output pos_y, output buttons,
        output delta_x, output delta_y, input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input buttons,
        input delta_x, input delta_y, output ready
    );
endinterface

/* rtl/core/ps2mpt_calc.sv */
// Packet math: deltas from the three bytes, cursor move and clamp.
module ps2mpt_calc #(
    parameter int COORD_BITS = 12
) (
    input  logic [7:0]               byte0,
    input  logic [7:0]               byte1,
    input  logic [7:0]               byte2,
    input  logic [COORD_BITS-1:0]    cur_x,
    input  logic [COORD_BITS-1:0]    cur_y,
    input  ps2mpt_pkg::scr_size_t    scr_w,
    input  ps2mpt_pkg::scr_size_t    scr_h,
    output logic [COORD_BITS-1:0]    new_x,
    output logic [COORD_BITS-1:0]    new_y,
    output ps2mpt_pkg::delta_t       dx,
    output ps2mpt_pkg::delta_t       dy
);
    import ps2mpt_pkg::*;

    // Width wide enough to compare a size register against 2^COORD_BITS
    localparam int LW = (COORD_BITS + 1 > SCR_BITS) ? COORD_BITS + 1 : SCR_BITS;
    // Signed width of cursor +/- delta
    localparam int SW = COORD_BITS + 2;

    localparam logic [LW-1:0] SIZE_CAP = LW'(1) << COORD_BITS;

    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic signed [SW-1:0]  sum_x;
    logic signed [SW-1:0]  sum_y;

    assign dx = {byte0[SIGN_X_BIT], byte1};
    assign dy = {byte0[SIGN_Y_BIT], byte2};

    // Largest legal coordinate: size-1, zero size counts as 1, size capped at 2^N
    always_comb
    begin
        if (scr_w == '0)
            lim_x = '0;
        else if (LW'(scr_w) > SIZE_CAP)
            lim_x = '1;
        else
            lim_x = COORD_BITS'(LW'(scr_w) - LW'(1));

        if (scr_h == '0)
            lim_y = '0;
        else if (LW'(scr_h) > SIZE_CAP)
            lim_y = '1;
        else
            lim_y = COORD_BITS'(LW'(scr_h) - LW'(1));
    end

    // Screen y grows downward, so dy is subtracted
    assign sum_x = $signed({2'b00, cur_x}) + SW'(dx);
    assign sum_y = $signed({2'b00, cur_y}) - SW'(dy);

    always_comb
    begin
        if (sum_x < 0)
            new_x = '0;
        else if (sum_x > $signed({2'b00, lim_x}))
            new_x = lim_x;
        else
            new_x = COORD_BITS'(sum_x);

        if (sum_y < 0)
            new_y = '0;
        else if (sum_y > $signed({2'b00, lim_y}))
            new_y = lim_y;
        else
            new_y = COORD_BITS'(sum_y);
    end

endmodule

/* rtl/core/ps2_mouse_packet_tracker.sv */
// Channel  | Dir | Payload                                   | Transaction
// ---------+-----+-------------------------------------------+----------------------
// byte_ch  | in  | data_byte[7:0], from_aux                  | one controller byte
// pkt_ch   | out | pos_x, pos_y, buttons[2:0], delta_x/y[8:0] | one decoded packet
// APB      | in  | paddr[2:0], pwdata[31:0] -> prdata        | screen size regs
//
// A byte is registered in the input stage on accept and processed from there;
// the third mouse byte of a packet then loads its result into the result register.
// Throughput: one byte per cycle, but for a third byte stalled by a held result.
// The combinational add/clamp against the cursor registers closes the cursor loop.
// Reset puts the cursor at the centre of the default 640x480 screen and the
// byte counter at packet start. A result held on pkt_ch stalls only the
// third byte of the next packet; other bytes keep flowing.
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ps2mpt_in_if.sink                          byte_ch,
    ps2mpt_out_if.source                       pkt_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ps2mpt_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [ps2mpt_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [ps2mpt_pkg::PDATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import ps2mpt_pkg::*;

    // Centre of the reset screen, with the same size rules as the clamp
    localparam int CAP     = 2 ** COORD_BITS;
    localparam int W_EFF   = (int'(SCREEN_W_RESET) > CAP) ? CAP : int'(SCREEN_W_RESET);
    localparam int H_EFF   = (int'(SCREEN_H_RESET) > CAP) ? CAP : int'(SCREEN_H_RESET);
    localparam logic [COORD_BITS-1:0] CUR_X_RESET = COORD_BITS'(W_EFF / 2);
    localparam logic [COORD_BITS-1:0] CUR_Y_RESET = COORD_BITS'(H_EFF / 2);

    // Config registers
    scr_size_t scr_w_reg;
    scr_size_t scr_h_reg;
    logic      cfg_wr;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_aux_reg;
    logic       s1_last;
    logic       s1_fire;

    // Packet state
    byte_idx_t             byte_idx_reg;
    logic [7:0]            held0_reg;
    logic [7:0]            held1_reg;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic [COORD_BITS-1:0] cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_next;
    delta_t                dx;
    delta_t                dy;

    // Result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [2:0]            buttons_reg;
    delta_t                delta_x_reg;
    delta_t                delta_y_reg;

    //------------------------------------------------------------------
    // APB: zero-wait, writes land on the access phase
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= SCREEN_W_RESET;
            scr_h_reg <= SCREEN_H_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_SCREEN_W: scr_w_reg <= pwdata[SCR_BITS-1:0];
                ADDR_SCREEN_H: scr_h_reg <= pwdata[SCR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_SCREEN_W: prdata = PDATA_BITS'(scr_w_reg);
            ADDR_SCREEN_H: prdata = PDATA_BITS'(scr_h_reg);
            default:       prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Input stage. Only the packet-closing byte can stall, and only while
    // the previous result is still waiting on pkt_ch.
    //------------------------------------------------------------------
    assign s1_last = s1_aux_reg && (byte_idx_reg == BYTE_IDX_LAST);
    assign s1_fire = s1_valid_reg && (!s1_last || !out_valid_reg || pkt_ch.ready);
    assign byte_ch.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            s1_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            s1_byte_reg <= byte_ch.data_byte;
            s1_aux_reg  <= byte_ch.from_aux;
        end
    end

    //------------------------------------------------------------------
    // Packet assembly; keyboard-port bytes pass through without effect
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_idx_reg <= '0;
        else if (s1_fire && s1_aux_reg)
            byte_idx_reg <= s1_last ? '0 : byte_idx_reg + 2'd1;
    end

    // Held bytes have no reset; they are always written before use
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_aux_reg && !s1_last)
        begin
            if (byte_idx_reg[0])
                held1_reg <= s1_byte_reg;
            else
                held0_reg <= s1_byte_reg;
        end
    end

    ps2mpt_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_calc (
        .byte0 (held0_reg),
        .byte1 (held1_reg),
        .byte2 (s1_byte_reg),
        .cur_x (cursor_x_reg),
        .cur_y (cursor_y_reg),
        .scr_w (scr_w_reg),
        .scr_h (scr_h_reg),
        .new_x (cursor_x_next),
        .new_y (cursor_y_next),
        .dx    (dx),
        .dy    (dy)
    );

    // Cursor moves only when a packet closes; a size change alone leaves it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= CUR_X_RESET;
            cursor_y_reg <= CUR_Y_RESET;
        end
        else if (s1_fire && s1_last)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last)
            out_valid_reg <= 1'b1;
        else if (pkt_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last)
        begin
            pos_x_reg   <= cursor_x_next;
            pos_y_reg   <= cursor_y_next;
            buttons_reg <= held0_reg[2:0];
            delta_x_reg <= dx;
            delta_y_reg <= dy;
        end
    end

    assign pkt_ch.valid   = out_valid_reg;
    assign pkt_ch.pos_x   = pos_x_reg;
    assign pkt_ch.pos_y   = pos_y_reg;
    assign pkt_ch.buttons = buttons_reg;
    assign pkt_ch.delta_x = delta_x_reg;
    assign pkt_ch.delta_y = delta_y_reg;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------

    // A new result only follows a packet-closing mouse byte
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last)
    ) else $error("result raised without a closing packet byte");

    // A pending result always matches the live cursor
    a_result_cursor: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pos_x_reg == cursor_x_reg) && (pos_y_reg == cursor_y_reg)
    ) else $error("pending result diverged from cursor");

    // Keyboard-port bytes never advance packet assembly
    a_kbd_ignored: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_aux_reg) |=> $stable(byte_idx_reg)
    ) else $error("non-mouse byte moved the byte counter");

endmodule

/* dv/ps2mpt_checker.sv */
`timescale 1ns / 100ps

module ps2mpt_checker
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ps2mpt_in_if                  byte_mon,
    ps2mpt_out_if                 pkt_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output int                    fail_count,
    output int                    pending,
    output int                    packets_checked
);

    localparam int SCREEN_MAX = 1 << COORD_BITS;

    typedef struct {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [2:0]            buttons;
        delta_t                delta_x;
        delta_t                delta_y;
    } packet_t;

    packet_t    expected_pkts[$];
    packet_t    oldest;
    scr_size_t  width_reg;
    scr_size_t  height_reg;
    byte_idx_t  byte_idx;
    logic [7:0] held[2];
    int         cur_x;
    int         cur_y;

    // zero counts as 1, anything past the coordinate range as the full range
    function automatic int usable_size(scr_size_t v);
        if (v == '0)
            return 1;
        if (int'(v) > SCREEN_MAX)
            return SCREEN_MAX;
        return int'(v);
    endfunction

    function automatic int clamp_to(int v, int size);
        if (v < 0)
            return 0;
        if (v > size - 1)
            return size - 1;
        return v;
    endfunction

    function automatic void check_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic reset_tracker();
        width_reg  = SCREEN_W_RESET;
        height_reg = SCREEN_H_RESET;
        byte_idx   = '0;
        held[0]    = '0;
        held[1]    = '0;
        cur_x      = usable_size(SCREEN_W_RESET) / 2;
        cur_y      = usable_size(SCREEN_H_RESET) / 2;
        expected_pkts.delete();
    endtask

    // third byte closes the packet; screen y grows downward, so dy is subtracted
    task automatic track_packet(logic [7:0] last_byte);
        packet_t p;
        int      dx;
        int      dy;
        dx = int'(held[1]) - (held[0][SIGN_X_BIT] ? 256 : 0);
        dy = int'(last_byte) - (held[0][SIGN_Y_BIT] ? 256 : 0);
        cur_x = clamp_to(cur_x + dx, usable_size(width_reg));
        cur_y = clamp_to(cur_y - dy, usable_size(height_reg));
        p.pos_x   = cur_x[COORD_BITS-1:0];
        p.pos_y   = cur_y[COORD_BITS-1:0];
        p.buttons = held[0][2:0];
        p.delta_x = dx[8:0];
        p.delta_y = dy[8:0];
        expected_pkts.push_back(p);
    endtask

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        packets_checked = 0;
        reset_tracker();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_tracker();
        end
        else
        begin
            if (pkt_mon.valid && pkt_mon.ready)
            begin
                if (expected_pkts.size() == 0)
                begin
                    $error("unexpected packet: pos_x %0d pos_y %0d",
                           pkt_mon.pos_x, pkt_mon.pos_y);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_pkts.pop_front();
                    check_field("pos_x", oldest.pos_x, pkt_mon.pos_x);
                    check_field("pos_y", oldest.pos_y, pkt_mon.pos_y);
                    check_field("buttons", oldest.buttons, pkt_mon.buttons);
                    check_field("delta_x", oldest.delta_x, pkt_mon.delta_x);
                    check_field("delta_y", oldest.delta_y, pkt_mon.delta_y);
                    packets_checked++;
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_SCREEN_W: width_reg  = pwdata[SCR_BITS-1:0];
                    ADDR_SCREEN_H: height_reg = pwdata[SCR_BITS-1:0];
                    default: ;
                endcase
            end

            if (byte_mon.valid && byte_mon.ready && byte_mon.from_aux)
            begin
                if (byte_idx != BYTE_IDX_LAST)
                begin
                    held[byte_idx[0]] = byte_mon.data_byte;
                    byte_idx++;
                end
                else
                begin
                    track_packet(byte_mon.data_byte);
                    byte_idx = '0;
                end
            end

            pending = expected_pkts.size();
        end
    end

endmodule

/* dv/tb_ps2_mouse_packet_tracker.sv */
`timescale 1ns / 100ps

// Top: makes the byte traffic, the screen size writes and the output stalls,
// and gives the verdict. All prediction and comparison lives in the checker.
module tb_ps2_mouse_packet_tracker;
    import ps2mpt_pkg::*;

    localparam int COORD_BITS = 12;

    // {from_aux, data_byte} opening traffic at the reset screen (640x480):
    // controller bytes at both data extremes, all buttons with zero motion,
    // +127 on both axes, both signs set with zero magnitude (-256) and
    // a controller byte slipped into the middle of that packet, a pull past
    // the left edge, -255 on both axes, then +255 steps.
    localparam logic [8:0] OPENING[24] = '{
        9'h0FF, 9'h000,
        9'h107, 9'h100, 9'h100,
        9'h108, 9'h17F, 9'h17F,
        9'h138, 9'h05A, 9'h100, 9'h100,
        9'h118, 9'h100, 9'h100,
        9'h13F, 9'h101, 9'h101,
        9'h100, 9'h1FF, 9'h100,
        9'h100, 9'h1FF, 9'h1FF
    };

    typedef struct {
        logic [7:0] data;
        logic       aux;
    } ctl_byte_t;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    ps2mpt_in_if                               byte_ch ();
    ps2mpt_out_if #(.COORD_BITS(COORD_BITS))   pkt_ch ();

    int fail_count;
    int pending;
    int packets_checked;

    ctl_byte_t tx_bytes[$];
    int        n_mouse;
    int        n_ignored;
    int        n_settings;
    bit        long_hold;

    ps2_mouse_packet_tracker #(.COORD_BITS(COORD_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .pkt_ch  (pkt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ps2mpt_checker #(.COORD_BITS(COORD_BITS)) tracker_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_mon        (byte_ch),
        .pkt_mon         (pkt_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .packets_checked (packets_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #2_400_000;
        $display("== FAIL ==");
        $finish;
    end

    // Output side: rotates between always ready, mostly ready and mostly
    // stalled. A long hold, counted here, backs the block up into its input.
    initial
    begin
        int cyc;
        bit hold_done;
        cyc       = 0;
        hold_done = 1'b0;
        pkt_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                pkt_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else
            begin
                case ((cyc / 80) % 3)
                    0:       pkt_ch.ready <= 1'b1;
                    1:       pkt_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: pkt_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic queue_byte(logic [7:0] data, logic aux);
        tx_bytes.push_back('{data, aux});
        if (aux)
            n_mouse++;
        else
            n_ignored++;
    endtask

    // Mostly well-formed packets with small motion so the cursor wanders
    // inside the screen; some full-range and extreme ones, some with sign
    // bits that disagree, some fragments that shift the packet framing.
    // A controller byte may land anywhere in the packet.
    task automatic push_packet();
        int         kind;
        int         dx;
        int         dy;
        int         noise_at;
        logic [8:0] vx;
        logic [8:0] vy;
        logic [7:0] pkt[3];
        kind     = $urandom_range(0, 9);
        noise_at = $urandom_range(0, 7);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 2)) queue_byte(8'($urandom), 1'b1);
            return;
        end
        if (kind <= 5)
        begin
            dx = $urandom_range(0, 48) - 24;
            dy = $urandom_range(0, 48) - 24;
        end
        else if (kind <= 7)
        begin
            dx = $urandom_range(0, 511) - 256;
            dy = $urandom_range(0, 511) - 256;
        end
        else
        begin
            dx = $urandom_range(0, 1) ? 255 : -256;
            dy = $urandom_range(0, 1) ? 255 : -256;
        end
        vx     = dx[8:0];
        vy     = dy[8:0];
        pkt[0] = 8'($urandom);
        if (kind != 7)
        begin
            pkt[0][SIGN_X_BIT] = vx[8];
            pkt[0][SIGN_Y_BIT] = vy[8];
        end
        pkt[1] = vx[7:0];
        pkt[2] = vy[7:0];
        for (int i = 0; i < 3; i++)
        begin
            if (i == noise_at)
                queue_byte(8'($urandom), 1'b0);
            queue_byte(pkt[i], 1'b1);
        end
    endtask

    // Sends the queue in bursts with random gaps; starts and ends at a falling edge.
    task automatic run_bytes();
        int burst;
        int gap;
        while (tx_bytes.size() != 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && tx_bytes.size() != 0)
            begin
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= tx_bytes[0].data;
                byte_ch.from_aux  <= tx_bytes[0].aux;
                @(posedge clk);
                while (!byte_ch.ready) @(posedge clk);
                void'(tx_bytes.pop_front());
                burst--;
                @(negedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_ch.valid     <= 1'b0;
                byte_ch.data_byte <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        byte_ch.valid <= 1'b0;
    endtask

    task automatic cfg_write(logic [PADDR_BITS-1:0] addr, logic [PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits are junk; only the low 13 bits reach the register.
    task automatic set_screen(scr_size_t w, scr_size_t h);
        logic [PDATA_BITS-1:0] word;
        word = $urandom;
        word[SCR_BITS-1:0] = w;
        cfg_write(ADDR_SCREEN_W, word);
        word = $urandom;
        word[SCR_BITS-1:0] = h;
        cfg_write(ADDR_SCREEN_H, word);
        n_settings++;
    endtask

    // Drain, then give a half-packet in flight time to finish.
    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        scr_size_t w;
        scr_size_t h;
        int        mark;

        n_mouse           = 0;
        n_ignored         = 0;
        n_settings        = 0;
        long_hold         = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.from_aux  = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (OPENING[i])
            queue_byte(OPENING[i][7:0], OPENING[i][8]);
        run_bytes();
        settle();

        // zero width counts as 1 (x pinned at 0), oversize height as 4096
        set_screen(13'd0, 13'h1FFF);
        queue_byte(8'h30, 1'b1);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h80, 1'b1);
        run_bytes();
        settle();

        // Random phases, each under its own screen size; the first four
        // cover the smallest, the exact maximum, the masked extremes and
        // the reset size. The sixth phase carries the long output hold.
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    w = 13'd1;
                    h = 13'd1;
                end
                1:
                begin
                    w = 13'd4096;
                    h = 13'd4096;
                end
                2:
                begin
                    w = 13'h1FFF;
                    h = 13'd0;
                end
                3:
                begin
                    w = SCREEN_W_RESET;
                    h = SCREEN_H_RESET;
                end
                default:
                begin
                    w = SCR_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                              : $urandom_range(0, 8191));
                    h = SCR_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                              : $urandom_range(0, 8191));
                end
            endcase
            set_screen(w, h);
            mark = n_mouse;
            while (n_mouse - mark < 50)
                push_packet();
            if (phase == 5)
                long_hold = 1'b1;
            run_bytes();
            settle();
        end

        repeat (20) @(negedge clk);

        $display("Run covered %0d mouse bytes and %0d ignored controller bytes,",
                 n_mouse, n_ignored);
        $display("%0d packets checked over %0d screen size settings.",
                 packets_checked, n_settings + 1);
        if (pending != 0)
            $error("%0d expected packets never arrived", pending);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
